[design/trcq_pkg.sv]
// ----------------------------------------------------------------------------
// trcq_pkg: shared types and constants of the release collision queue
// Holds the transaction payload types, the record layouts of the pending and
// history stores, the sequencer states and the signed offset helpers.
// ----------------------------------------------------------------------------
package trcq_pkg;

  localparam int DEF_PENDING_DEPTH = 64;
  localparam int DEF_HISTORY_DEPTH = 16;
  localparam int DEF_SENDER_SLOTS  = 8;

  localparam int          CFG_AW       = 3;
  localparam logic        REG_LEAD     = 1'b0;
  localparam logic        REG_SHIFT    = 1'b1;
  localparam logic [23:0] LEAD_RESET   = 24'd20000;
  localparam logic [5:0]  SHIFT_RESET  = 6'd10;
  localparam logic [7:0]  CORRUPT_MASK = 8'hA5;

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] sender_id;
    logic [7:0]  data_byte;
    logic [62:0] tx_time_us;
    logic [15:0] duration_us;
    logic [62:0] now_us;
    logic        flush;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  out_byte;
    logic [31:0] out_sender;
    logic [62:0] out_time_us;
    logic        collided;
    logic        insert_dropped;
    logic        arrived_late;
    logic [31:0] collision_total;
    logic [31:0] late_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] sender;
    logic [62:0] tx_time;
    logic [15:0] duration;
    logic [7:0]  data;
  } pend_rec_t;

  typedef struct packed {
    logic [62:0] start_t;
    logic [63:0] end_t;
    logic [31:0] sender;
  } hist_rec_t;

  typedef struct packed {
    logic        en;
    logic        inc;
    logic [31:0] sender;
    logic [63:0] offset;
    logic [62:0] updated;
  } org_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_START,
    ST_LRU,
    ST_INS_SUM,
    ST_INS_CLAMP,
    ST_INS_NEW,
    ST_INS_FIN,
    ST_SEL_RD,
    ST_SEL_MATCH,
    ST_SEL_EV,
    ST_SEL_DONE,
    ST_OV_RD,
    ST_OV_EV,
    ST_COMMIT_RD,
    ST_COMMIT_WR
  } state_t;

  function automatic logic [63:0] sat_add_s64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if ((a[63] == b[63]) && (r[63] != a[63])) begin
      r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return r;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input logic [5:0] sh);
    return 64'($signed(v) >>> sh);
  endfunction

  function automatic logic lt_s64(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

[design/trcq_ram.sv]
// ----------------------------------------------------------------------------
// trcq_ram: single write, single read record store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trcq_ram #(
  parameter int WIDTH = $bits(trcq_pkg::pend_rec_t),
  parameter int DEPTH = trcq_pkg::DEF_PENDING_DEPTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

[design/trcq_origin.sv]
// ----------------------------------------------------------------------------
// trcq_origin: per-sender clock offset table
// Associative lookup of a sender, one indexed read port and one write port,
// with the count of allocated slots.
// ----------------------------------------------------------------------------
module trcq_origin #(
  parameter int SENDER_SLOTS = trcq_pkg::DEF_SENDER_SLOTS,
  localparam int SIW = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1,
  localparam int SCW = $clog2(SENDER_SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          lookup_id,
  output logic                 match_found,
  output logic [SIW-1:0]       match_idx,
  input  logic [SIW-1:0]       rd_idx,
  output logic [63:0]          rd_offset,
  output logic [62:0]          rd_updated,
  input  logic [SIW-1:0]       wr_idx,
  input  trcq_pkg::org_wr_t    wr,
  output logic [SCW-1:0]       count
);
  import trcq_pkg::*;

  logic [31:0]    sender_r  [SENDER_SLOTS];
  logic [63:0]    offset_r  [SENDER_SLOTS];
  logic [62:0]    updated_r [SENDER_SLOTS];
  logic [SCW-1:0] count_r;

  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    for (int s = SENDER_SLOTS - 1; s >= 0; s--) begin
      if ((SCW'(s) < count_r) && (sender_r[s] == lookup_id)) begin
        match_found = 1'b1;
        match_idx   = SIW'(s);
      end
    end
  end

  assign rd_offset  = offset_r[rd_idx];
  assign rd_updated = updated_r[rd_idx];
  assign count      = count_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      sender_r[wr_idx]  <= wr.sender;
      offset_r[wr_idx]  <= wr.offset;
      updated_r[wr_idx] <= wr.updated;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (wr.en && wr.inc) begin
      count_r <= count_r + 1'b1;
    end
  end

endmodule

[design/timestamp_release_collision_queue.sv]
// ----------------------------------------------------------------------------
// timestamp_release_collision_queue: reorder window with collision marking
// An insert updates the offset of a known sender, takes a free slot for a new
// one, replaces the least recently updated slot when all are taken, or is
// dropped when the pending table is full. A release commits the earliest due
// pending record, marked if it overlaps a history or pending record, and repeats
// until none is due. Output stalls add delay; one transaction runs at a time.
// Reset (synchronous, active low) empties all tables and restores the registers.
// ----------------------------------------------------------------------------
module timestamp_release_collision_queue #(
  parameter int PENDING_DEPTH = trcq_pkg::DEF_PENDING_DEPTH,
  parameter int HISTORY_DEPTH = trcq_pkg::DEF_HISTORY_DEPTH,
  parameter int SENDER_SLOTS  = trcq_pkg::DEF_SENDER_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  trcq_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output trcq_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trcq_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import trcq_pkg::*;

  localparam int PIW = $clog2(PENDING_DEPTH);
  localparam int PCW = $clog2(PENDING_DEPTH + 1);
  localparam int HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int SIW = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
  localparam int SCW = $clog2(SENDER_SLOTS + 1);
  localparam int JW  = (PCW > HCW) ? PCW : HCW;

  state_t state_r, state_nxt;

  in_item_t       req_r;
  logic [PCW-1:0] pcnt_r;
  logic [HCW-1:0] hcnt_r;
  logic [HIW-1:0] hhead_r;
  logic [62:0]    newest_r;
  logic [31:0]    colcnt_r;
  logic [31:0]    latecnt_r;
  logic [23:0]    lead_r;
  logic [5:0]     shift_r;
  logic [PCW-1:0] i_r;
  logic [JW-1:0]  j_r;
  logic           ph_r;
  logic [SIW-1:0] k_r;
  logic           col_r;
  logic           best_v_r;
  logic           hold_v_r;
  logic           out_valid_r;

  logic [SIW-1:0] slot_r;
  logic           newslot_r;
  logic [63:0]    sh_r;
  logic [63:0]    sum_r;
  logic           mf_r;
  logic [63:0]    off_r;
  logic [63:0]    tl_r;
  pend_rec_t      ent_r;
  pend_rec_t      best_r;
  logic [PIW-1:0] best_idx_r;
  logic [62:0]    lru_upd_r;
  out_item_t      hold_r;
  out_item_t      out_r;

  logic           pend_we;
  logic [PIW-1:0] pend_wa, pend_ra;
  pend_rec_t      pend_wd, pend_rd;
  logic           hist_we;
  logic [HIW-1:0] hist_wa, hist_ra;
  hist_rec_t      hist_wd, hist_rd;

  logic [31:0]    org_lookup;
  logic           org_mf;
  logic [SIW-1:0] org_midx;
  logic [SIW-1:0] org_ridx;
  logic [63:0]    org_roff;
  logic [62:0]    org_rupd;
  org_wr_t        org_wr;
  logic [SCW-1:0] org_cnt;

  logic           cfg_wr;
  logic           out_free;
  logic           pfull;
  logic           ofull;
  logic [63:0]    s_val;
  logic           late_now;
  logic [31:0]    latecnt_inc;
  logic [31:0]    colcnt_inc;
  logic           due;
  logic [65:0]    due_sum;
  logic [63:0]    t0_best;
  logic [63:0]    t1_best;
  logic [63:0]    o1_pend;
  logic           ov_hit;
  logic [7:0]     c_byte;
  logic [7:0]     v_byte;
  logic [PCW-1:0] pcnt_dec;
  logic           out_load;
  out_item_t      out_item;

  trcq_ram #(.WIDTH($bits(pend_rec_t)), .DEPTH(PENDING_DEPTH)) u_pend (
    .clk (clk), .we (pend_we), .wa (pend_wa), .wd (pend_wd),
    .ra (pend_ra), .rd (pend_rd)
  );

  trcq_ram #(.WIDTH($bits(hist_rec_t)), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk (clk), .we (hist_we), .wa (hist_wa), .wd (hist_wd),
    .ra (hist_ra), .rd (hist_rd)
  );

  trcq_origin #(.SENDER_SLOTS(SENDER_SLOTS)) u_origin (
    .clk (clk), .rst_n (rst_n), .lookup_id (org_lookup),
    .match_found (org_mf), .match_idx (org_midx),
    .rd_idx (org_ridx), .rd_offset (org_roff), .rd_updated (org_rupd),
    .wr_idx (slot_r), .wr (org_wr), .count (org_cnt)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SHIFT) ? {26'd0, shift_r} : {8'd0, lead_r};

  // Shared arithmetic and compare terms.
  assign out_free    = !out_valid_r || out_ready;
  assign pfull       = (pcnt_r == PCW'(PENDING_DEPTH));
  assign ofull       = (org_cnt == SCW'(SENDER_SLOTS));
  assign s_val       = {1'b0, req_r.now_us} - {1'b0, req_r.tx_time_us};
  assign late_now    = req_r.tx_time_us < newest_r;
  assign latecnt_inc = (latecnt_r == 32'hFFFF_FFFF) ? latecnt_r : latecnt_r + 32'd1;
  assign colcnt_inc  = (colcnt_r == 32'hFFFF_FFFF) ? colcnt_r : colcnt_r + 32'd1;
  assign due_sum     = {2'b00, tl_r} + {{2{off_r[63]}}, off_r};
  assign due         = req_r.flush || !mf_r ||
                       ($signed(due_sum) <= $signed({3'b000, req_r.now_us}));
  assign t0_best     = {1'b0, best_r.tx_time};
  assign t1_best     = t0_best + 64'(best_r.duration);
  assign o1_pend     = {1'b0, pend_rd.tx_time} + 64'(pend_rd.duration);
  assign c_byte      = best_r.data | CORRUPT_MASK;
  assign v_byte      = !col_r ? best_r.data : ((c_byte == best_r.data) ? ~best_r.data : c_byte);
  assign pcnt_dec    = pcnt_r - 1'b1;

  always_comb begin
    if (!ph_r) begin
      ov_hit = (hist_rd.sender != best_r.sender) && (t0_best < hist_rd.end_t) &&
               ({1'b0, hist_rd.start_t} < t1_best);
    end else begin
      ov_hit = (pend_rd.sender != best_r.sender) && (t0_best < o1_pend) &&
               ({1'b0, pend_rd.tx_time} < t1_best);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.req_type == REQ_RELEASE) ? ST_SEL_RD : ST_INS_START;
        end
      end
      ST_INS_START: begin
        if (pfull) begin
          if (out_free) state_nxt = ST_IDLE;
        end else if (org_mf) begin
          state_nxt = ST_INS_SUM;
        end else if (!ofull) begin
          state_nxt = ST_INS_NEW;
        end else begin
          state_nxt = ST_LRU;
        end
      end
      ST_LRU: begin
        if (k_r == SIW'(SENDER_SLOTS - 1)) state_nxt = ST_INS_NEW;
      end
      ST_INS_SUM:   state_nxt = ST_INS_CLAMP;
      ST_INS_CLAMP: state_nxt = ST_INS_FIN;
      ST_INS_NEW:   state_nxt = ST_INS_FIN;
      ST_INS_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_SEL_RD: begin
        state_nxt = (i_r == pcnt_r) ? ST_SEL_DONE : ST_SEL_MATCH;
      end
      ST_SEL_MATCH: state_nxt = ST_SEL_EV;
      ST_SEL_EV:    state_nxt = ST_SEL_RD;
      ST_SEL_DONE: begin
        if (!hold_v_r || out_free) begin
          state_nxt = best_v_r ? ST_OV_RD : ST_IDLE;
        end
      end
      ST_OV_RD: begin
        if (!ph_r) begin
          if (j_r != JW'(hcnt_r)) state_nxt = ST_OV_EV;
        end else if (j_r == JW'(pcnt_r)) begin
          state_nxt = ST_COMMIT_RD;
        end else if (j_r != JW'(best_idx_r)) begin
          state_nxt = ST_OV_EV;
        end
      end
      ST_OV_EV:     state_nxt = ST_OV_RD;
      ST_COMMIT_RD: state_nxt = ST_COMMIT_WR;
      ST_COMMIT_WR: state_nxt = ST_SEL_RD;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    pend_we    = 1'b0;
    pend_wa    = best_idx_r;
    pend_wd    = pend_rd;
    pend_ra    = i_r[PIW-1:0];
    hist_we    = 1'b0;
    hist_wa    = hhead_r;
    hist_wd    = '{start_t: best_r.tx_time, end_t: t1_best, sender: best_r.sender};
    hist_ra    = j_r[HIW-1:0];
    org_lookup = req_r.sender_id;
    org_ridx   = slot_r;
    org_wr     = '{en: 1'b0, inc: 1'b0, sender: req_r.sender_id, offset: s_val,
                   updated: req_r.now_us};
    out_load   = 1'b0;
    out_item   = '0;
    unique case (state_r)
      ST_INS_START: begin
        org_ridx = org_midx;
        if (pfull && out_free) begin
          out_load                = 1'b1;
          out_item.result_kind    = KIND_STATUS;
          out_item.insert_dropped = 1'b1;
          out_item.collision_total = colcnt_r;
          out_item.late_total     = latecnt_r;
          out_item.last           = 1'b1;
        end
      end
      ST_LRU: org_ridx = k_r;
      ST_INS_CLAMP: begin
        org_wr.en = 1'b1;
        if (!lt_s64(s_val, sum_r)) org_wr.offset = sum_r;
      end
      ST_INS_NEW: begin
        org_wr.en  = 1'b1;
        org_wr.inc = newslot_r;
      end
      ST_INS_FIN: begin
        if (out_free) begin
          pend_we  = 1'b1;
          pend_wa  = pcnt_r[PIW-1:0];
          pend_wd  = '{sender: req_r.sender_id, tx_time: req_r.tx_time_us,
                       duration: req_r.duration_us, data: req_r.data_byte};
          out_load = 1'b1;
          out_item.result_kind     = KIND_STATUS;
          out_item.arrived_late    = late_now;
          out_item.collision_total = colcnt_r;
          out_item.late_total      = late_now ? latecnt_inc : latecnt_r;
          out_item.last            = 1'b1;
        end
      end
      ST_SEL_MATCH: begin
        org_lookup = pend_rd.sender;
        org_ridx   = org_midx;
      end
      ST_SEL_DONE: begin
        if (hold_v_r && out_free) begin
          out_load      = 1'b1;
          out_item      = hold_r;
          out_item.last = !best_v_r;
        end
      end
      ST_OV_RD: begin
        pend_ra = j_r[PIW-1:0];
      end
      ST_COMMIT_RD: begin
        pend_ra = pcnt_dec[PIW-1:0];
      end
      ST_COMMIT_WR: begin
        pend_we = (best_idx_r != pcnt_dec[PIW-1:0]);
        hist_we = 1'b1;
        if (hcnt_r != HCW'(HISTORY_DEPTH)) hist_wa = hcnt_r[HIW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pcnt_r      <= '0;
      hcnt_r      <= '0;
      hhead_r     <= '0;
      newest_r    <= '0;
      colcnt_r    <= '0;
      latecnt_r   <= '0;
      lead_r      <= LEAD_RESET;
      shift_r     <= SHIFT_RESET;
      i_r         <= '0;
      j_r         <= '0;
      ph_r        <= 1'b0;
      k_r         <= '0;
      col_r       <= 1'b0;
      best_v_r    <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_LEAD) lead_r <= pwdata[23:0];
        else shift_r <= pwdata[5:0];
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          i_r      <= '0;
          k_r      <= '0;
          best_v_r <= 1'b0;
        end
        ST_LRU: k_r <= k_r + 1'b1;
        ST_INS_FIN: begin
          if (out_free) begin
            pcnt_r <= pcnt_r + 1'b1;
            if (late_now) latecnt_r <= latecnt_inc;
          end
        end
        ST_SEL_EV: begin
          if (due && (!best_v_r || (ent_r.tx_time < best_r.tx_time))) best_v_r <= 1'b1;
          i_r <= i_r + 1'b1;
        end
        ST_SEL_DONE: begin
          if (hold_v_r && out_free) hold_v_r <= 1'b0;
          j_r   <= '0;
          ph_r  <= 1'b0;
          col_r <= 1'b0;
        end
        ST_OV_RD: begin
          if (!ph_r && (j_r == JW'(hcnt_r))) begin
            ph_r <= 1'b1;
            j_r  <= '0;
          end else if (ph_r && (j_r != JW'(pcnt_r)) && (j_r == JW'(best_idx_r))) begin
            j_r <= j_r + 1'b1;
          end
        end
        ST_OV_EV: begin
          if (ov_hit) col_r <= 1'b1;
          j_r <= j_r + 1'b1;
        end
        ST_COMMIT_WR: begin
          pcnt_r <= pcnt_dec;
          if (hcnt_r != HCW'(HISTORY_DEPTH)) begin
            hcnt_r <= hcnt_r + 1'b1;
          end else begin
            hhead_r <= (hhead_r == HIW'(HISTORY_DEPTH - 1)) ? '0 : hhead_r + 1'b1;
          end
          if (best_r.tx_time > newest_r) newest_r <= best_r.tx_time;
          if (col_r) colcnt_r <= colcnt_inc;
          hold_v_r <= 1'b1;
          i_r      <= '0;
          best_v_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    if (out_load) out_r <= out_item;
    unique case (state_r)
      ST_INS_START: begin
        sh_r <= asr64({1'b0, req_r.now_us} - {1'b0, org_rupd}, shift_r);
        if (org_mf) begin
          slot_r <= org_midx;
        end else begin
          slot_r    <= org_cnt[SIW-1:0];
          newslot_r <= !ofull;
        end
      end
      ST_LRU: begin
        if ((k_r == '0) || (org_rupd < lru_upd_r)) begin
          lru_upd_r <= org_rupd;
          slot_r    <= k_r;
        end
      end
      ST_INS_SUM: sum_r <= sat_add_s64(org_roff, sh_r);
      ST_SEL_MATCH: begin
        mf_r  <= org_mf;
        off_r <= org_roff;
        ent_r <= pend_rd;
        tl_r  <= {1'b0, pend_rd.tx_time} + 64'(lead_r);
      end
      ST_SEL_EV: begin
        if (due && (!best_v_r || (ent_r.tx_time < best_r.tx_time))) begin
          best_r     <= ent_r;
          best_idx_r <= i_r[PIW-1:0];
        end
      end
      ST_COMMIT_WR: begin
        hold_r <= '{result_kind: KIND_RECORD, out_byte: v_byte, out_sender: best_r.sender,
                    out_time_us: best_r.tx_time, collided: col_r, insert_dropped: 1'b0,
                    arrived_late: 1'b0, collision_total: col_r ? colcnt_inc : colcnt_r,
                    late_total: latecnt_r, last: 1'b0};
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCW'(PENDING_DEPTH))
    else $error("pending count exceeds table depth");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> (state_r != ST_IDLE))
    else $error("released record held while the sequencer is idle");

  a_drop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_START && pfull && out_free) |=> (out_valid_r && out_r.insert_dropped))
    else $error("insert into a full table did not report a drop");

endmodule
